// ===== src/ksa_pkg.sv =====
// ----------------------------------------------------------------------------
// ksa_pkg: shared types and constants of the keyed slot allocator
// Field widths, hash and key constants, status codes and the request and
// response words passed between the sequencer and the slot table.
// ----------------------------------------------------------------------------
package ksa_pkg;

    localparam int CHAR_W    = 7;
    localparam int KEY_W     = 20;
    localparam int SLOT_W    = 5;
    localparam int STATUS_W  = 3;
    localparam int HASH_W    = 64;

    // djb2: h*33 = (h << 5) + h
    localparam int FOLD_SHIFT = 5;
    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;

    localparam logic [KEY_W:0] KEY_MODULUS = 21'd1000000;

    // key = hash mod 1000000 by long division in 16-bit digits, a quotient
    // step then a remainder step per digit. 1000000 = 64 * 15625, so each digit
    // quotient is ((x >> 6) * ceil(2^44 / 15625)) >> 44, exact for x below 2^36.
    localparam int DIGIT_W     = 16;
    localparam int DIGITS      = HASH_W / DIGIT_W;
    localparam int X_W         = KEY_W + DIGIT_W;   // remainder:digit
    localparam int PRE_SHIFT   = 6;
    localparam int RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP = 31'd1125899907;
    localparam int RECIP_SHIFT = 44;
    localparam int PROD_W      = X_W - PRE_SHIFT + RECIP_W;
    localparam int RED_STEPS   = 2 * DIGITS;
    localparam int RED_CNT_W   = $clog2(RED_STEPS);

    typedef enum logic {
        OP_PARK  = 1'b0,
        OP_LEAVE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_FULL      = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_RELEASED  = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
    } t_tbl_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_number;
        logic [KEY_W-1:0]  issued_key;
    } t_tbl_rsp;

endpackage

// ===== src/ksa_if.sv =====
// ----------------------------------------------------------------------------
// ksa_if: request and response channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ksa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ksa_pkg::CHAR_W-1:0]  plate_char;
    logic                        plate_last;
    logic [ksa_pkg::KEY_W-1:0]   leave_key;

    modport source (output valid, output op, output plate_char, output plate_last,
                    output leave_key, input ready);
    modport sink   (input valid, input op, input plate_char, input plate_last,
                    input leave_key, output ready);
endinterface

interface ksa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ksa_pkg::STATUS_W-1:0]  status;
    logic [ksa_pkg::SLOT_W-1:0]    slot_number;
    logic [ksa_pkg::KEY_W-1:0]     issued_key;

    modport source (output valid, output status, output slot_number,
                    output issued_key, input ready);
    modport sink   (input valid, input status, input slot_number,
                    input issued_key, output ready);
endinterface

// ===== src/ksa_hash.sv =====
// ----------------------------------------------------------------------------
// ksa_hash: djb2 plate hash and key reduction
// Folds one character per word; on the last one the hash is reduced mod
// 1000000 by long division in 16-bit digits, a quotient and a remainder step each.
// ----------------------------------------------------------------------------
module ksa_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fold,
    input  logic [ksa_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output logic                        o_key_valid,
    output logic [ksa_pkg::KEY_W-1:0]   o_key
);

    logic [ksa_pkg::HASH_W-1:0]    r_acc;
    logic [ksa_pkg::HASH_W-1:0]    r_work;
    logic [ksa_pkg::KEY_W-1:0]     r_rem;
    logic [ksa_pkg::X_W-1:0]       r_x;
    logic [ksa_pkg::DIGIT_W-1:0]   r_q;
    logic [ksa_pkg::RED_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_key_valid;

    logic [ksa_pkg::HASH_W-1:0]    n_fold;
    logic [ksa_pkg::X_W-1:0]       n_x;
    logic [ksa_pkg::PROD_W-1:0]    n_prod;
    logic [ksa_pkg::DIGIT_W-1:0]   n_q;
    logic [ksa_pkg::KEY_W-1:0]     n_rem;

    // zero character adds nothing
    always_comb begin
        if (i_char != '0) begin
            n_fold = (r_acc << ksa_pkg::FOLD_SHIFT) + r_acc
                   + ksa_pkg::HASH_W'(i_char);
        end else begin
            n_fold = r_acc;
        end
    end

    // even step: next digit joins the remainder, quotient by reciprocal
    // odd step: remainder = x - q*1000000, always below the modulus
    always_comb begin
        n_x    = {r_rem, r_work[ksa_pkg::HASH_W-1 -: ksa_pkg::DIGIT_W]};
        n_prod = ksa_pkg::PROD_W'(n_x >> ksa_pkg::PRE_SHIFT)
               * ksa_pkg::PROD_W'(ksa_pkg::RECIP);
        n_q    = n_prod[ksa_pkg::RECIP_SHIFT +: ksa_pkg::DIGIT_W];
        n_rem  = ksa_pkg::KEY_W'(r_x - ksa_pkg::X_W'(r_q)
                                     * ksa_pkg::X_W'(ksa_pkg::KEY_MODULUS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= ksa_pkg::HASH_SEED;
            r_busy      <= 1'b0;
            r_key_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_key_valid <= 1'b0;
            if (i_fold) begin
                if (i_last) begin
                    r_acc  <= ksa_pkg::HASH_SEED;
                    r_work <= n_fold;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end else begin
                    r_acc <= n_fold;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + ksa_pkg::RED_CNT_W'(1);
                if (!r_cnt[0]) begin
                    r_x    <= n_x;
                    r_q    <= n_q;
                    r_work <= r_work << ksa_pkg::DIGIT_W;
                end else begin
                    r_rem <= n_rem;
                end
                if (r_cnt == ksa_pkg::RED_CNT_W'(ksa_pkg::RED_STEPS - 1)) begin
                    r_busy      <= 1'b0;
                    r_key_valid <= 1'b1;
                end
            end
        end
    end

    assign o_key_valid = r_key_valid;
    assign o_key       = r_rem;

endmodule

// ===== src/ksa_table.sv =====
// ----------------------------------------------------------------------------
// ksa_table: slot table with scan and commit
// Keys sit in a synchronous memory, occupied marks in flops. A scan reads
// every slot once, noting the lowest free slot and the lowest matching key,
// then the commit state updates the table and forms the response.
// ----------------------------------------------------------------------------
module ksa_table #(
    parameter int SLOT_COUNT = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ksa_pkg::t_tbl_req i_req,
    output logic              o_done,
    output ksa_pkg::t_tbl_rsp o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state                     r_state;
    ksa_pkg::t_tbl_req          r_req;
    logic [SLOT_COUNT-1:0]      r_occ;
    logic [CNT_W-1:0]           r_rd_idx;
    logic                       r_cmp_vld;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic [ksa_pkg::KEY_W-1:0]  r_rd_data;
    logic                       r_free_fnd;
    logic [IDX_W-1:0]           r_free_idx;
    logic                       r_match_fnd;
    logic [IDX_W-1:0]           r_match_idx;
    logic                       r_done;
    ksa_pkg::t_tbl_rsp          r_rsp;

    logic [ksa_pkg::KEY_W-1:0]  r_key_mem [SLOT_COUNT];

    logic                       rd_en;
    logic                       cmp_occ;
    logic                       hit_free;
    logic                       hit_match;
    logic                       grant;
    logic                       mem_we;
    logic [ksa_pkg::SLOT_W-1:0] free_slot_no;
    logic [ksa_pkg::SLOT_W-1:0] match_slot_no;

    always_comb begin
        rd_en     = (r_state == S_SCAN) && (r_rd_idx < CNT_W'(SLOT_COUNT));
        cmp_occ   = r_occ[r_cmp_idx];
        hit_free  = r_cmp_vld && !cmp_occ && !r_free_fnd;
        hit_match = r_cmp_vld && cmp_occ && (r_rd_data == r_req.key) && !r_match_fnd;
        grant     = (r_req.op == ksa_pkg::OP_PARK) && r_free_fnd && !r_match_fnd;
        mem_we    = (r_state == S_COMMIT) && grant;
        // one-based, wrapped to the field width
        free_slot_no  = ksa_pkg::SLOT_W'(CNT_W'(r_free_idx) + CNT_W'(1));
        match_slot_no = ksa_pkg::SLOT_W'(CNT_W'(r_match_idx) + CNT_W'(1));
    end

    // key store; a free slot's key is never looked at
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_mem[r_free_idx] <= r_req.key;
        end
        if (rd_en) begin
            r_rd_data <= r_key_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req       <= i_req;
                        r_rd_idx    <= '0;
                        r_cmp_vld   <= 1'b0;
                        r_free_fnd  <= 1'b0;
                        r_match_fnd <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= rd_en;
                    r_cmp_idx <= r_rd_idx[IDX_W-1:0];
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (hit_free) begin
                        r_free_fnd <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                    if (hit_match) begin
                        r_match_fnd <= 1'b1;
                        r_match_idx <= r_cmp_idx;
                    end
                    if (!rd_en && !r_cmp_vld) begin
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    priority if (r_req.op == ksa_pkg::OP_PARK && !r_free_fnd) begin
                        r_rsp.status      <= ksa_pkg::ST_FULL;
                        r_rsp.slot_number <= '0;
                        r_rsp.issued_key  <= '0;
                    end else if (r_req.op == ksa_pkg::OP_PARK && r_match_fnd) begin
                        r_rsp.status      <= ksa_pkg::ST_DUPLICATE;
                        r_rsp.slot_number <= '0;
                        r_rsp.issued_key  <= r_req.key;
                    end else if (r_req.op == ksa_pkg::OP_PARK) begin
                        r_occ[r_free_idx] <= 1'b1;
                        r_rsp.status      <= ksa_pkg::ST_GRANTED;
                        r_rsp.slot_number <= free_slot_no;
                        r_rsp.issued_key  <= r_req.key;
                    end else if (r_match_fnd) begin
                        r_occ[r_match_idx] <= 1'b0;
                        r_rsp.status       <= ksa_pkg::ST_RELEASED;
                        r_rsp.slot_number  <= match_slot_no;
                        r_rsp.issued_key   <= '0;
                    end else begin
                        r_rsp.status      <= ksa_pkg::ST_UNKNOWN;
                        r_rsp.slot_number <= '0;
                        r_rsp.issued_key  <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== src/keyed_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_allocator: hashed-key slot allocator
// Response: a plate character that is not last gives none; a leave word
//   gives one after the slot scan, the last plate character one after the
//   mod 1000000 reduction and the slot scan.
// Throughput: one request at a time, set by the slot scan (one memory read a
//   cycle) and the digit-by-digit key reduction; a response waiting on the
//   output does not block the next request.
// Reset: synchronous, active low; every slot free, hash at its seed value.
// ----------------------------------------------------------------------------
module keyed_slot_allocator #(
    parameter int SLOT_COUNT = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ksa_req_if.sink    i_req,
    ksa_rsp_if.source  o_rsp
);

    // Flow
    //  - Each plate character word is folded into the djb2 hash at once.
    //  - The last character starts the key reduction; the key then drives
    //    a table scan. A leave word starts the scan straight away.
    //  - The table result goes to the output register, or, if a previous
    //    word is still waiting there, into a pending register.
    // Requests are taken only in S_IDLE.

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_PEND
    } t_state;

    t_state                     r_state;
    logic                       r_out_valid;
    ksa_pkg::t_tbl_rsp          r_out;
    ksa_pkg::t_tbl_rsp          r_pend;

    logic                       req_acc;
    logic                       req_leave;
    logic                       out_free;
    logic                       out_load;
    logic                       hash_fold;
    logic                       hash_key_vld;
    logic [ksa_pkg::KEY_W-1:0]  hash_key;
    logic                       tbl_start;
    ksa_pkg::t_tbl_req          tbl_req;
    logic                       tbl_done;
    ksa_pkg::t_tbl_rsp          tbl_rsp;

    always_comb begin
        req_acc   = i_req.valid && (r_state == S_IDLE);
        req_leave = (i_req.op == ksa_pkg::OP_LEAVE);
        // output register can take a word this cycle
        out_free  = !r_out_valid || o_rsp.ready;
        // a result word moves into the output register
        out_load  = ((r_state == S_SCAN) && tbl_done && out_free)
                 || ((r_state == S_PEND) && out_free);
        hash_fold = req_acc && !req_leave;
        tbl_start = (req_acc && req_leave) || ((r_state == S_HASH) && hash_key_vld);
        tbl_req.op  = (r_state == S_HASH) ? ksa_pkg::OP_PARK : ksa_pkg::OP_LEAVE;
        tbl_req.key = (r_state == S_HASH) ? hash_key : i_req.leave_key;
    end

    ksa_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fold      (hash_fold),
        .i_char      (i_req.plate_char),
        .i_last      (i_req.plate_last),
        .o_key_valid (hash_key_vld),
        .o_key       (hash_key)
    );

    ksa_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tbl_start),
        .i_req   (tbl_req),
        .o_done  (tbl_done),
        .o_rsp   (tbl_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        if (req_leave) begin
                            r_state <= S_SCAN;
                        end else if (i_req.plate_last) begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_key_vld) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tbl_done) begin
                        if (out_free) begin
                            r_out   <= tbl_rsp;
                            r_state <= S_IDLE;
                        end else begin
                            r_pend  <= tbl_rsp;
                            r_state <= S_PEND;
                        end
                    end
                end
                S_PEND: begin
                    if (out_free) begin
                        r_out   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.slot_number = r_out.slot_number;
    assign o_rsp.issued_key  = r_out.issued_key;

    // key only arrives while the sequencer waits for it
    a_key_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_key_vld |-> (r_state == S_HASH))
        else $error("hash key outside hash wait");

    // table finishes only while a scan is outstanding
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_done |-> (r_state == S_SCAN))
        else $error("table done outside scan");

    // a pending word exists only behind a full output register
    a_pend_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEND) |-> r_out_valid)
        else $error("pending word with free output");

    // issued keys are reduced
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out.issued_key} < ksa_pkg::KEY_MODULUS))
        else $error("issued key out of range");

endmodule

// ===== dv/keyed_slot_allocator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_slot_allocator_tb: self-checking bench for the keyed slot allocator
// Plate and leave words go in, and a slot table model predicts every response.
// Directed corner cases run first. Random fill and drain phases then follow,
// with repeated plates and stray keys. Both channels stall at random.
// ----------------------------------------------------------------------------
module keyed_slot_allocator_tb;

    localparam int SLOT_COUNT   = 20;
    localparam int TARGET_WORDS = 1000;
    localparam int IDLE_PCT     = 26;
    localparam int MAX_PLATE    = 8;
    localparam int POOL_DEPTH   = 32;
    localparam int REPORT_MAX   = 10;

    // one request word as the driver presents it
    typedef struct packed {
        ksa_pkg::t_op               op;
        logic [ksa_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic [ksa_pkg::KEY_W-1:0]  leave_key;
    } t_req_word;

    // a plate kept for reuse, so the same key comes back as a duplicate
    typedef struct packed {
        logic [3:0]                                len;
        logic [MAX_PLATE-1:0][ksa_pkg::CHAR_W-1:0] chars;
    } t_plate;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ksa_req_if req_if ();
    ksa_rsp_if rsp_if ();

    keyed_slot_allocator #(
        .SLOT_COUNT (SLOT_COUNT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Slot table model: the bench's own copy of the hash and the table
    // ------------------------------------------------------------------------
    logic [ksa_pkg::HASH_W-1:0] plate_hash;
    logic                       slot_busy [SLOT_COUNT];
    logic [ksa_pkg::KEY_W-1:0]  slot_tag  [SLOT_COUNT];

    t_req_word         pending_words [$];
    ksa_pkg::t_tbl_rsp expected_rsp  [$];
    t_req_word         cur_word;

    int words_accepted = 0;
    int rsp_seen       = 0;
    int error_count    = 0;
    int status_seen [5];

    // djb2 step; a zero character adds nothing, like a string terminator
    function automatic logic [ksa_pkg::HASH_W-1:0] fold_char(
        input logic [ksa_pkg::HASH_W-1:0] h,
        input logic [ksa_pkg::CHAR_W-1:0] ch);
        if (ch == '0)
            return h;
        return (h << ksa_pkg::FOLD_SHIFT) + h + ksa_pkg::HASH_W'(ch);
    endfunction

    function automatic logic [ksa_pkg::KEY_W-1:0] key_from_hash(
        input logic [ksa_pkg::HASH_W-1:0] h);
        logic [ksa_pkg::HASH_W-1:0] rem;
        rem = h % ksa_pkg::HASH_W'(ksa_pkg::KEY_MODULUS);
        return rem[ksa_pkg::KEY_W-1:0];
    endfunction

    // lowest occupied slot holding the key, -1 if none; free slots never match
    function automatic int find_key(input logic [ksa_pkg::KEY_W-1:0] key);
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot_busy[i] && slot_tag[i] == key)
                return i;
        return -1;
    endfunction

    // apply one accepted word to the table and queue the response it causes
    task automatic allocate_or_release(input t_req_word w);
        logic [ksa_pkg::KEY_W-1:0] key;
        int                        free_idx;
        int                        hit_idx;
        ksa_pkg::t_tbl_rsp         r;

        r = '0;
        if (w.op == ksa_pkg::OP_PARK) begin
            plate_hash = fold_char(plate_hash, w.ch);
            if (!w.last)
                return;
            key        = key_from_hash(plate_hash);
            plate_hash = ksa_pkg::HASH_SEED;
            free_idx   = -1;
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
                if (!slot_busy[i])
                    free_idx = i;
            if (free_idx < 0) begin
                r.status = ksa_pkg::ST_FULL;
            end else if (find_key(key) >= 0) begin
                r.status     = ksa_pkg::ST_DUPLICATE;
                r.issued_key = key;
            end else begin
                slot_busy[free_idx] = 1'b1;
                slot_tag[free_idx]  = key;
                r.status      = ksa_pkg::ST_GRANTED;
                r.slot_number = ksa_pkg::SLOT_W'(free_idx + 1);
                r.issued_key  = key;
            end
        end else begin
            hit_idx = find_key(w.leave_key);
            if (hit_idx < 0) begin
                r.status = ksa_pkg::ST_UNKNOWN;
            end else begin
                slot_busy[hit_idx] = 1'b0;
                slot_tag[hit_idx]  = '0;
                r.status      = ksa_pkg::ST_RELEASED;
                r.slot_number = ksa_pkg::SLOT_W'(hit_idx + 1);
            end
        end
        expected_rsp.push_back(r);
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit take_break(input bit quiet);
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: one word at a time from pending_words, valid held until
    // taken. The model is updated at the edge where the word is accepted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.op         <= ksa_pkg::OP_PARK;
            req_if.plate_char <= '0;
            req_if.plate_last <= 1'b0;
            req_if.leave_key  <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                allocate_or_release(cur_word);
                words_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                // a stretch of words with no gaps in the middle of the run
                if (pending_words.size() != 0 &&
                    !take_break(words_accepted >= 350 && words_accepted < 500)) begin
                    cur_word = pending_words.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.op         <= cur_word.op;
                    req_if.plate_char <= cur_word.ch;
                    req_if.plate_last <= cur_word.last;
                    req_if.leave_key  <= cur_word.leave_key;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: random back-pressure, each word checked against the
    // oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_seen++;
                if (rsp_if.status < 5)
                    status_seen[rsp_if.status]++;
                if (expected_rsp.size() == 0) begin
                    flag_error($sformatf("unexpected response status %0d slot %0d key %0d",
                                         rsp_if.status, rsp_if.slot_number,
                                         rsp_if.issued_key));
                end else begin
                    ksa_pkg::t_tbl_rsp e;
                    e = expected_rsp.pop_front();
                    if (rsp_if.status != e.status)
                        flag_error($sformatf("status exp %0d got %0d",
                                             e.status, rsp_if.status));
                    if (rsp_if.slot_number != e.slot_number)
                        flag_error($sformatf("slot_number exp %0d got %0d",
                                             e.slot_number, rsp_if.slot_number));
                    if (rsp_if.issued_key != e.issued_key)
                        flag_error($sformatf("issued_key exp %0d got %0d",
                                             e.issued_key, rsp_if.issued_key));
                end
            end
            rsp_if.ready <= !take_break(rsp_seen >= 90 && rsp_seen < 140);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic push_park(input logic [ksa_pkg::CHAR_W-1:0] ch, input logic last);
        t_req_word w;
        w.op        = ksa_pkg::OP_PARK;
        w.ch        = ch;
        w.last      = last;
        w.leave_key = ksa_pkg::KEY_W'($urandom);    // ignored on a park word
        pending_words.push_back(w);
    endtask

    task automatic push_leave(input logic [ksa_pkg::KEY_W-1:0] key);
        t_req_word w;
        w.op        = ksa_pkg::OP_LEAVE;
        w.ch        = ksa_pkg::CHAR_W'($urandom);   // ignored on a leave word
        w.last      = 1'($urandom);
        w.leave_key = key;
        pending_words.push_back(w);
    endtask

    // a key that most likely matches nothing; half drawn from the whole key field
    function automatic logic [ksa_pkg::KEY_W-1:0] stray_key();
        if ($urandom_range(0, 1) == 0)
            return ksa_pkg::KEY_W'($urandom_range(0, 999999));
        return ksa_pkg::KEY_W'($urandom_range(0, (1 << ksa_pkg::KEY_W) - 1));
    endfunction

    // mostly plate-like characters, sometimes anything including zero
    function automatic logic [ksa_pkg::CHAR_W-1:0] plate_char_pick();
        int r;
        if ($urandom_range(0, 99) < 10)
            return ksa_pkg::CHAR_W'($urandom_range(0, 127));
        r = $urandom_range(0, 35);
        return (r < 26) ? ksa_pkg::CHAR_W'(8'h41 + r) : ksa_pkg::CHAR_W'(8'h30 + r - 26);
    endfunction

    function automatic logic [ksa_pkg::KEY_W-1:0] plate_key(input t_plate p);
        logic [ksa_pkg::HASH_W-1:0] h;
        h = ksa_pkg::HASH_SEED;
        for (int i = 0; i < p.len; i++)
            h = fold_char(h, p.chars[i]);
        return key_from_hash(h);
    endfunction

    t_plate                    plate;
    t_plate                    plate_pool [$];
    logic [ksa_pkg::KEY_W-1:0] live_keys  [$];
    logic [ksa_pkg::KEY_W-1:0] key_a;
    int                        phase;
    int                        pick;
    bit                        fill;

    initial begin
        i_rst_n    = 1'b0;
        plate_hash = ksa_pkg::HASH_SEED;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = '0;
        end
        for (int i = 0; i < 5; i++)
            status_seen[i] = 0;

        // directed corners
        push_park('0, 1'b1);            // empty plate: key is the seed mod 1000000
        push_park('0, 1'b1);            // same again: duplicate
        push_leave(ksa_pkg::KEY_W'(5381));       // released
        push_leave('0);                 // key 0 against free slots: unknown
        push_park(7'h41, 1'b0);
        push_leave(ksa_pkg::KEY_W'(999999));     // leave in mid-plate, hash untouched
        push_park('0, 1'b0);            // zero char in the middle is skipped
        push_park(7'h7F, 1'b1);
        key_a = key_from_hash(fold_char(fold_char(ksa_pkg::HASH_SEED, 7'h41), 7'h7F));
        push_park(7'h01, 1'b1);
        push_leave(ksa_pkg::KEY_W'(1000000));    // out of key range, never matches
        push_leave({ksa_pkg::KEY_W{1'b1}});
        push_park(7'h2A, 1'b0);
        push_park(7'h55, 1'b1);
        push_leave(key_a);              // released
        push_leave(key_a);              // now unknown

        // random phases: fill phases run the table full, drain phases empty it
        phase = 0;
        while (pending_words.size() < TARGET_WORDS) begin
            fill = (phase % 2 == 0);
            repeat (30) begin
                if ($urandom_range(0, 99) < (fill ? 85 : 30)) begin
                    if (plate_pool.size() != 0 && $urandom_range(0, 99) < 15) begin
                        plate = plate_pool[$urandom_range(0, plate_pool.size() - 1)];
                    end else begin
                        plate = '0;
                        plate.len = 4'($urandom_range(1, MAX_PLATE));
                        for (int i = 0; i < plate.len; i++)
                            plate.chars[i] = plate_char_pick();
                        plate_pool.push_back(plate);
                        if (plate_pool.size() > POOL_DEPTH)
                            void'(plate_pool.pop_front());
                    end
                    live_keys.push_back(plate_key(plate));
                    for (int i = 0; i < plate.len; i++) begin
                        push_park(plate.chars[i], i == plate.len - 1);
                        // now and then a leave cuts into the plate
                        if (i != plate.len - 1 && $urandom_range(0, 99) < 5)
                            push_leave(stray_key());
                    end
                end else if (live_keys.size() != 0 && $urandom_range(0, 99) < 80) begin
                    pick = $urandom_range(0, live_keys.size() - 1);
                    push_leave(live_keys[pick]);
                    live_keys.delete(pick);
                end else begin
                    push_leave(stray_key());
                end
            end
            phase++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (SLOT_COUNT + 40) @(posedge i_clk);

        $display("%0d request words, %0d responses in %0d fill/drain phases", words_accepted,
                 rsp_seen, phase);
        $display("granted %0d, full %0d, duplicate %0d, released %0d, unknown %0d",
                 status_seen[ksa_pkg::ST_GRANTED], status_seen[ksa_pkg::ST_FULL],
                 status_seen[ksa_pkg::ST_DUPLICATE], status_seen[ksa_pkg::ST_RELEASED],
                 status_seen[ksa_pkg::ST_UNKNOWN]);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog: far beyond the slowest run with every stall
    initial begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", expected_rsp.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
